/* src/summed_area_table_query_top_macros.svh */
`ifndef SUMMED_AREA_TABLE_QUERY_TOP_MACROS_SVH
`define SUMMED_AREA_TABLE_QUERY_TOP_MACROS_SVH

// same-cycle implication, checked on clk and quiet while in reset
`define SATQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SATQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/satq_pkg.sv */
package satq_pkg;

  localparam int MAX_ROWS_DEF     = 64;
  localparam int MAX_COLS_DEF     = 64;
  localparam int ELEMENT_BITS_DEF = 16;

  localparam int ELEM_W    = 16;
  localparam int COORD_W   = 6;
  localparam int SIZE_W    = 7;
  localparam int SUM_W     = 28;
  localparam int CFG_IDX_W = 2;
  // wide enough for any row or column index plus one
  localparam int IDX_EXT_W = 11;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ORDER      = 2'd1,
    ST_SIZE       = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  typedef struct packed {
    logic                     action;
    logic signed [ELEM_W-1:0] element_value;
    logic [COORD_W-1:0]       row_top;
    logic [COORD_W-1:0]       col_left;
    logic [COORD_W-1:0]       row_bottom;
    logic [COORD_W-1:0]       col_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] rect_sum;
    status_t                 status;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    logic              restart;
  } size_ctrl_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned lim);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > lim) begin
      r = SIZE_W'(lim);
    end
    return r;
  endfunction

endpackage

/* src/satq_addsub.sv */
module satq_addsub #(
  parameter int W = satq_pkg::SUM_W
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] y
);

  // shared wrapping adder, subtracts by adding the complement plus one
  assign y = a + (b ^ {W{sub}}) + W'(sub);

endmodule

/* src/satq_core.sv */
module satq_core #(
  parameter int MAX_ROWS     = satq_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = satq_pkg::MAX_COLS_DEF,
  parameter int ELEMENT_BITS = satq_pkg::ELEMENT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  satq_pkg::in_item_t   in_data,
  input  satq_pkg::size_ctrl_t ctrl,
  input  logic                 res_take,
  output logic                 res_valid,
  output satq_pkg::out_item_t  res_data
);

  import satq_pkg::*;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LRD  = 5'b00010,
    S_LADD = 5'b00100,
    S_QRUN = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   load_row_r;
  logic [COL_W-1:0]   load_col_r;
  logic [SUM_W-1:0]   row_sum_r;
  logic               complete_r;
  logic [2:0]         step_r;
  in_item_t           item_r;
  logic [SUM_W-1:0]   acc_r;
  out_item_t          res_r;
  logic [SUM_W-1:0]   rdata_r;
  logic [SUM_W-1:0]   mem [DEPTH];

  logic [SUM_W-1:0]   alu_a, alu_b, alu_y;
  logic               alu_sub;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;

  logic [31:0]                     elem_raw;
  logic signed [ELEMENT_BITS-1:0]  elem_cut;
  logic [SUM_W-1:0]                elem_sum;

  logic               q_order, q_size;
  status_t            q_status;
  logic [IDX_EXT_W-1:0] r1m_e, c1m_e, r2_e, c2_e, ldr_m_e, col_inc, row_inc;
  logic [ROW_W-1:0]   r1m, r2, ldr_m;
  logic [COL_W-1:0]   c1m, c2;
  logic [1:0]         term;
  logic               term_en, term_sub;

  // element sign-extended from its low ELEMENT_BITS bits
  assign elem_raw = {16'b0, item_r.element_value};
  assign elem_cut = elem_raw[ELEMENT_BITS-1:0];
  assign elem_sum = SUM_W'(elem_cut);

  // query checks, lowest code wins
  assign q_order = (in_data.row_top > in_data.row_bottom) ||
                   (in_data.col_left > in_data.col_right);
  assign q_size  = (SIZE_W'(in_data.row_bottom) >= ctrl.rows) ||
                   (SIZE_W'(in_data.col_right) >= ctrl.cols);

  always_comb begin
    if (q_order) begin
      q_status = ST_ORDER;
    end else if (q_size) begin
      q_status = ST_SIZE;
    end else if (!complete_r) begin
      q_status = ST_INCOMPLETE;
    end else begin
      q_status = ST_OK;
    end
  end

  assign r2_e  = IDX_EXT_W'(item_r.row_bottom);
  assign c2_e  = IDX_EXT_W'(item_r.col_right);
  assign r1m_e = IDX_EXT_W'(item_r.row_top) - IDX_EXT_W'(1);
  assign c1m_e = IDX_EXT_W'(item_r.col_left) - IDX_EXT_W'(1);
  assign r2    = r2_e[ROW_W-1:0];
  assign c2    = c2_e[COL_W-1:0];
  assign r1m   = r1m_e[ROW_W-1:0];
  assign c1m   = c1m_e[COL_W-1:0];

  assign ldr_m_e = IDX_EXT_W'(load_row_r) - IDX_EXT_W'(1);
  assign ldr_m   = ldr_m_e[ROW_W-1:0];
  assign col_inc = IDX_EXT_W'(load_col_r) + IDX_EXT_W'(1);
  assign row_inc = IDX_EXT_W'(load_row_r) + IDX_EXT_W'(1);

  // term handled this step is the one read on the previous step
  assign term = 2'(step_r - 3'd1);

  always_comb begin
    case (term)
      2'd0: begin
        term_en  = 1'b1;
        term_sub = 1'b0;
      end
      2'd1: begin
        term_en  = (item_r.row_top != '0);
        term_sub = 1'b1;
      end
      2'd2: begin
        term_en  = (item_r.col_left != '0);
        term_sub = 1'b1;
      end
      default: begin
        term_en  = (item_r.row_top != '0) && (item_r.col_left != '0);
        term_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (step_r)
      3'd1:    mem_addr = {r1m, c2};
      3'd2:    mem_addr = {r2, c1m};
      3'd3:    mem_addr = {r1m, c1m};
      default: mem_addr = {r2, c2};
    endcase
    if (state_r == S_LRD) begin
      mem_addr = {ldr_m, load_col_r};
    end else if (state_r == S_LADD) begin
      mem_addr = {load_row_r, load_col_r};
    end
  end

  assign mem_we = (state_r == S_LADD);

  always_comb begin
    alu_a   = acc_r;
    alu_b   = term_en ? rdata_r : '0;
    alu_sub = term_sub;
    case (state_r)
      S_LRD: begin
        alu_a   = (load_col_r == '0) ? '0 : row_sum_r;
        alu_b   = elem_sum;
        alu_sub = 1'b0;
      end
      S_LADD: begin
        alu_a   = row_sum_r;
        alu_b   = (load_row_r != '0) ? rdata_r : '0;
        alu_sub = 1'b0;
      end
      default: begin
      end
    endcase
  end

  satq_addsub #(.W(SUM_W)) u_addsub (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.action == ACT_LOAD) begin
            state_nxt = S_LRD;
          end else if (q_status != ST_OK) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_QRUN;
          end
        end
      end
      S_LRD:  state_nxt = S_LADD;
      S_LADD: state_nxt = S_FIN;
      S_QRUN: begin
        if (step_r == 3'd4) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      load_row_r <= '0;
      load_col_r <= '0;
      row_sum_r  <= '0;
      complete_r <= 1'b0;
      step_r     <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          step_r <= '0;
          // a load into a finished table starts a new one, position is already at the origin
          if (in_valid && in_data.action == ACT_LOAD) begin
            complete_r <= 1'b0;
          end
        end
        S_LRD: begin
          row_sum_r <= alu_y;
        end
        S_LADD: begin
          if (col_inc >= IDX_EXT_W'(ctrl.cols)) begin
            load_col_r <= '0;
            if (row_inc >= IDX_EXT_W'(ctrl.rows)) begin
              load_row_r <= '0;
              complete_r <= 1'b1;
            end else begin
              load_row_r <= row_inc[ROW_W-1:0];
            end
          end else begin
            load_col_r <= col_inc[COL_W-1:0];
          end
        end
        S_QRUN: begin
          step_r <= step_r + 3'd1;
        end
        default: begin
        end
      endcase
      if (ctrl.restart) begin
        load_row_r <= '0;
        load_col_r <= '0;
        row_sum_r  <= '0;
        complete_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        item_r <= in_data;
        acc_r  <= '0;
        res_r  <= '{rect_sum: '0, status: q_status};
      end
      S_LADD: begin
        res_r <= '{rect_sum: '0, status: ST_OK};
      end
      S_QRUN: begin
        if (step_r != '0) begin
          acc_r <= alu_y;
        end
        res_r <= '{rect_sum: alu_y, status: ST_OK};
      end
      default: begin
      end
    endcase
  end

  // single-port table, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= alu_y;
    end
    rdata_r <= mem[mem_addr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res_data  = res_r;

endmodule

/* src/summed_area_table_query_top.sv */
// Summed-area table with rectangle-sum queries.
// Input channel in_valid/in_stall/in_data: action load appends the next element
// in raster order over rows_in_use x cols_in_use; action query returns the sum
// of the inclusive rectangle row_top..row_bottom, col_left..col_right.
// Every input word gives exactly one result word on out_valid/out_stall/out_data
// (load: sum zero, status ok; faulty query: sum zero and the fault code).
// One item at a time, all table accesses through one single-port memory and
// one shared add/subtract unit:
//   load: read above, add row sum, add above and write
//   query: four reads pipelined into the accumulator
//   faulty query: result straight from the checks, no table reads
// A result sits in the output register while the next word is taken in;
// if that register is still stalled when the next result is ready, the
// block holds in_stall high until it drains.
// Config port cfg_valid/cfg_ready/cfg_index/cfg_data: 0 rows_in_use,
// 1 cols_in_use, values clamped to 1..max; a write to either restarts table loading.
// Reset (synchronous, rst_n low) sets both sizes to 64 clamped to the maximum,
// empties the output register and marks the table incomplete.
`include "summed_area_table_query_top_macros.svh"

module summed_area_table_query_top #(
  parameter int MAX_ROWS     = satq_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = satq_pkg::MAX_COLS_DEF,
  parameter int ELEMENT_BITS = satq_pkg::ELEMENT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  satq_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output satq_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [satq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [satq_pkg::SIZE_W-1:0]      cfg_data
);

  import satq_pkg::*;

  logic [SIZE_W-1:0] rows_r, rows_nxt;
  logic [SIZE_W-1:0] cols_r, cols_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  size_ctrl_t        ctrl;
  logic              res_valid, res_take;
  out_item_t         res_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    rows_nxt     = rows_r;
    cols_nxt     = cols_r;
    ctrl.rows    = rows_r;
    ctrl.cols    = cols_r;
    ctrl.restart = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        REG_ROWS: begin
          rows_nxt     = clamp_size(cfg_data, MAX_ROWS);
          ctrl.restart = 1'b1;
        end
        REG_COLS: begin
          cols_nxt     = clamp_size(cfg_data, MAX_COLS);
          ctrl.restart = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= clamp_size(SIZE_RESET, MAX_ROWS);
      cols_r <= clamp_size(SIZE_RESET, MAX_COLS);
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  satq_core #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // output word register, refilled as soon as it is empty or being taken
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SATQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "core took a word but is not busy")
  `SATQ_ASSERT_NOW(a_fault_sum_zero, out_valid && out_data.status != ST_OK, out_data.rect_sum == '0, "faulty query with nonzero sum")
  `SATQ_ASSERT_NEXT(a_result_lands, res_valid && res_take, out_valid, "finished result lost before output register")

endmodule
